// ----- sv/exi_pkg.sv -----
// Shared constants, a type and a ROM content function for the table-based exponential.
package exi_pkg;

  localparam int ARG_W        = 29;
  localparam int FRAC_BITS    = 20;
  // The fraction table step count is a power of two.
  localparam int FRAC_LOG2    = 10;
  localparam int FRAC_STEPS   = 1 << FRAC_LOG2;
  localparam int INT_SPAN     = 300;
  localparam int HALF_SPAN    = INT_SPAN / 2;

  localparam int R_W    = FRAC_LOG2 + 1;
  localparam int INT_W  = $clog2(INT_SPAN + 1);
  localparam int X_W    = ARG_W + 2;
  localparam int MS_W   = FRAC_BITS + 1;
  localparam int EXP_W  = 11;
  localparam int FRAC_W = 52;

  typedef logic [63:0] dbl_t;

  // Square-and-multiply power for a nonnegative integer exponent.
  function automatic real int_power(real base, int n);
    real acc;
    real b;
    int  e;
    acc = 1.0;
    b   = base;
    e   = n;
    while (e != 0) begin
      if ((e & 1) != 0) begin
        acc = acc * b;
      end
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

endpackage

// ----- sv/exp_table_interpolate.sv -----
// Top level of the table-based exponential with linear interpolation.
//
//   channel  signals                              direction  carries
//   arg      arg_valid, arg_ready, arg_value      in         one argument request
//   res      res_valid, res_ready, exp_bits,      out        exp(x) as a double and
//            was_clamped                                     the clamp flag
//
// The pipeline has six register stages, and one request can be accepted in every
// cycle unless a stalled output has backed the pipeline up to its first stage.
// Stage 1 clamps and splits the argument, stage 2 reads both tables, stages 3 and 4
// apply the interpolation scale, and stages 5 and 6 multiply by exp of the integer part.
// Reset clears only the valid bits of the stages; the tables are constant logic.
// Each stage holds while its successor is full and stalled, so an empty stage still
// takes a request while a finished result waits at the output.
module exp_table_interpolate import exi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    arg_valid,
  output logic                    arg_ready,
  input  logic signed [ARG_W-1:0] arg_value,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [63:0]             exp_bits,
  output logic                    was_clamped
);

  localparam int STAGES = 6;

  // One valid bit per pipeline stage and the advance enable that each stage uses.
  logic [STAGES:1] vld;
  logic [STAGES:1] adv;
  // The clamp flag rides beside the data from stage 2 onward.
  logic [STAGES:2] cl;

  logic [R_W-1:0]   r_idx;
  logic [INT_W-1:0] int_idx;
  logic [MS_W-1:0]  m1;
  logic             clamp1;
  dbl_t             frac_bits;
  dbl_t             int2;
  logic [MS_W-1:0]  m2;
  dbl_t             res4;
  dbl_t             int4;

  // A stage may load when it is empty or when the stage after it is loading too.
  always_comb begin
    adv[STAGES] = !vld[STAGES] || res_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign arg_ready   = adv[1];
  assign res_valid   = vld[STAGES];
  assign was_clamped = cl[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= arg_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cl[2] <= clamp1;
    end
    for (int k = 3; k <= STAGES; k++) begin
      if (adv[k]) begin
        cl[k] <= cl[k-1];
      end
    end
  end

  exi_front u_front (
    .clk       (clk),
    .en        (adv[1]),
    .arg_value (arg_value),
    .r_idx     (r_idx),
    .int_idx   (int_idx),
    .m_scale   (m1),
    .clamp     (clamp1)
  );

  exi_rom u_rom (
    .clk       (clk),
    .en        (adv[2]),
    .r_idx     (r_idx),
    .int_idx   (int_idx),
    .m_in      (m1),
    .frac_bits (frac_bits),
    .int_bits  (int2),
    .m_out     (m2)
  );

  exi_scale u_scale (
    .clk       (clk),
    .en        (adv[4:3]),
    .frac_bits (frac_bits),
    .int_in    (int2),
    .m_scale   (m2),
    .res_bits  (res4),
    .int_out   (int4)
  );

  exi_dmul u_dmul (
    .clk       (clk),
    .en        (adv[6:5]),
    .a_bits    (res4),
    .b_bits    (int4),
    .prod_bits (exp_bits)
  );

`ifndef SYNTHESIS
  // A draining output never holds back the input side.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> arg_ready)
    else $error("input stalled while the output drains");

  // Every result is a positive normal double.
  a_result_normal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!exp_bits[63] && exp_bits[62:52] != 11'd0 && exp_bits[62:52] != 11'h7ff))
    else $error("result is not a positive normal double");

  // A request accepted into an empty pipeline reaches the output once it has passed through every stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (arg_valid && arg_ready && vld == '0 && res_ready) |=> ##5 res_valid)
    else $error("result missing after the pipeline latency");
`endif

endmodule

// ----- sv/exi_front.sv -----
// Clamp of the argument and split into table indexes and the interpolation scale.
module exi_front import exi_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ARG_W-1:0] arg_value,
  output logic [R_W-1:0]          r_idx,
  output logic [INT_W-1:0]        int_idx,
  output logic [MS_W-1:0]         m_scale,
  output logic                    clamp
);

  localparam logic signed [X_W-1:0] LIM = X_W'(HALF_SPAN) <<< FRAC_BITS;
  localparam int IP_W = X_W - FRAC_BITS;

  logic signed [X_W-1:0] xe;
  logic signed [X_W-1:0] xc;
  logic [X_W-1:0]        u;
  logic [IP_W-1:0]       ip_full;
  logic [INT_W-1:0]      ip;
  logic [FRAC_BITS-1:0]  fpart;
  logic [MS_W-1:0]       fsum;
  logic [R_W-1:0]        r;
  logic [MS_W-1:0]       ms;
  logic                  over;
  logic                  under;

  always_comb begin
    xe    = X_W'(arg_value);
    over  = xe > LIM;
    under = xe < -LIM;
    if (over) begin
      xc = LIM;
    end else if (under) begin
      xc = -LIM;
    end else begin
      xc = xe;
    end
    // Offsetting by half the span turns the floor split into a plain bit split.
    u       = X_W'(xc + LIM);
    ip_full = u[X_W-1:FRAC_BITS];
    if (ip_full > IP_W'(INT_SPAN)) begin
      ip = INT_W'(INT_SPAN);
    end else begin
      ip = ip_full[INT_W-1:0];
    end
    fpart = u[FRAC_BITS-1:0];
    // Round half up to the nearest table step.
    fsum  = {1'b0, fpart} + MS_W'(1 << (FRAC_BITS - 1 - FRAC_LOG2));
    r     = fsum[FRAC_BITS -: R_W];
    // The scale 1 + residual/FRAC_STEPS is exact with FRAC_BITS fraction bits.
    ms    = {1'b0, fpart} - {r, {(FRAC_BITS - FRAC_LOG2){1'b0}}} + MS_W'(1 << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_idx   <= r;
      int_idx <= ip;
      m_scale <= ms;
      clamp   <= over | under;
    end
  end

endmodule

// ----- sv/exi_rom.sv -----
// Fraction and integer exponential tables with registered reads.
module exi_rom import exi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [R_W-1:0]   r_idx,
  input  logic [INT_W-1:0] int_idx,
  input  logic [MS_W-1:0]  m_in,
  output dbl_t             frac_bits,
  output dbl_t             int_bits,
  output logic [MS_W-1:0]  m_out
);

  dbl_t frac_tab [FRAC_STEPS+1];
  dbl_t int_tab  [INT_SPAN+1];

  // Each fraction entry is exp(k / FRAC_STEPS) as a 30-term Taylor sum, one term per constant.
  for (genvar k = 0; k <= FRAC_STEPS; k++) begin : g_frac
    localparam real Y   = real'(k) / real'(FRAC_STEPS);
    localparam real T1  = Y;
    localparam real T2  = T1 * Y / 2.0;
    localparam real T3  = T2 * Y / 3.0;
    localparam real T4  = T3 * Y / 4.0;
    localparam real T5  = T4 * Y / 5.0;
    localparam real T6  = T5 * Y / 6.0;
    localparam real T7  = T6 * Y / 7.0;
    localparam real T8  = T7 * Y / 8.0;
    localparam real T9  = T8 * Y / 9.0;
    localparam real T10 = T9 * Y / 10.0;
    localparam real T11 = T10 * Y / 11.0;
    localparam real T12 = T11 * Y / 12.0;
    localparam real T13 = T12 * Y / 13.0;
    localparam real T14 = T13 * Y / 14.0;
    localparam real T15 = T14 * Y / 15.0;
    localparam real T16 = T15 * Y / 16.0;
    localparam real T17 = T16 * Y / 17.0;
    localparam real T18 = T17 * Y / 18.0;
    localparam real T19 = T18 * Y / 19.0;
    localparam real T20 = T19 * Y / 20.0;
    localparam real T21 = T20 * Y / 21.0;
    localparam real T22 = T21 * Y / 22.0;
    localparam real T23 = T22 * Y / 23.0;
    localparam real T24 = T23 * Y / 24.0;
    localparam real T25 = T24 * Y / 25.0;
    localparam real T26 = T25 * Y / 26.0;
    localparam real T27 = T26 * Y / 27.0;
    localparam real T28 = T27 * Y / 28.0;
    localparam real T29 = T28 * Y / 29.0;
    localparam real S   = 1.0 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10
                          + T11 + T12 + T13 + T14 + T15 + T16 + T17 + T18 + T19 + T20
                          + T21 + T22 + T23 + T24 + T25 + T26 + T27 + T28 + T29;
    localparam dbl_t V  = $realtobits(S);
    assign frac_tab[k] = V;
  end

  // Each integer entry raises the series value of e or 1/e to the distance from the center.
  for (genvar j = 0; j <= INT_SPAN; j++) begin : g_int
    localparam int  N   = j - HALF_SPAN;
    localparam real Y   = (N >= 0) ? 1.0 : -1.0;
    localparam real T1  = Y;
    localparam real T2  = T1 * Y / 2.0;
    localparam real T3  = T2 * Y / 3.0;
    localparam real T4  = T3 * Y / 4.0;
    localparam real T5  = T4 * Y / 5.0;
    localparam real T6  = T5 * Y / 6.0;
    localparam real T7  = T6 * Y / 7.0;
    localparam real T8  = T7 * Y / 8.0;
    localparam real T9  = T8 * Y / 9.0;
    localparam real T10 = T9 * Y / 10.0;
    localparam real T11 = T10 * Y / 11.0;
    localparam real T12 = T11 * Y / 12.0;
    localparam real T13 = T12 * Y / 13.0;
    localparam real T14 = T13 * Y / 14.0;
    localparam real T15 = T14 * Y / 15.0;
    localparam real T16 = T15 * Y / 16.0;
    localparam real T17 = T16 * Y / 17.0;
    localparam real T18 = T17 * Y / 18.0;
    localparam real T19 = T18 * Y / 19.0;
    localparam real T20 = T19 * Y / 20.0;
    localparam real T21 = T20 * Y / 21.0;
    localparam real T22 = T21 * Y / 22.0;
    localparam real T23 = T22 * Y / 23.0;
    localparam real T24 = T23 * Y / 24.0;
    localparam real T25 = T24 * Y / 25.0;
    localparam real T26 = T25 * Y / 26.0;
    localparam real T27 = T26 * Y / 27.0;
    localparam real T28 = T27 * Y / 28.0;
    localparam real T29 = T28 * Y / 29.0;
    localparam real S   = 1.0 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10
                          + T11 + T12 + T13 + T14 + T15 + T16 + T17 + T18 + T19 + T20
                          + T21 + T22 + T23 + T24 + T25 + T26 + T27 + T28 + T29;
    localparam dbl_t V  = $realtobits(int_power(S, (N >= 0) ? N : -N));
    assign int_tab[j] = V;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac_bits <= frac_tab[r_idx];
      int_bits  <= int_tab[int_idx];
      m_out     <= m_in;
    end
  end

endmodule

// ----- sv/exi_scale.sv -----
// Two-stage product of a fraction table entry and the exact interpolation scale.
module exi_scale import exi_pkg::*; (
  input  logic            clk,
  input  logic [1:0]      en,
  input  dbl_t            frac_bits,
  input  dbl_t            int_in,
  input  logic [MS_W-1:0] m_scale,
  output dbl_t            res_bits,
  output dbl_t            int_out
);

  localparam int PH_W = 27 + MS_W;
  localparam int PL_W = 26 + MS_W;
  localparam int P_W  = PH_W + 26;

  logic [PH_W-1:0]  ph;
  logic [PL_W-1:0]  pl;
  logic [EXP_W-1:0] ef;
  dbl_t             int_mid;

  logic [P_W-1:0]   p;
  logic [P_W-1:0]   sh;
  logic [EXP_W:0]   ex;
  logic [52:0]      mant;
  logic [53:0]      mr;
  logic             g;
  logic             s;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ph      <= PH_W'({1'b1, frac_bits[51:26]}) * PH_W'(m_scale);
      pl      <= PL_W'(frac_bits[25:0]) * PL_W'(m_scale);
      ef      <= frac_bits[62:52];
      int_mid <= int_in;
    end
  end

  always_comb begin
    p = {ph, 26'b0} + P_W'(pl);
    // The product's leading one sits at one of the top three bits.
    if (p[P_W-1]) begin
      sh = p;
      ex = {1'b0, ef} + (EXP_W+1)'(1);
    end else if (p[P_W-2]) begin
      sh = p << 1;
      ex = {1'b0, ef};
    end else begin
      sh = p << 2;
      ex = {1'b0, ef} - (EXP_W+1)'(1);
    end
    mant = sh[P_W-1 -: 53];
    g    = sh[P_W-54];
    s    = |sh[P_W-55:0];
    mr   = {1'b0, mant} + 54'(g & (s | mant[0]));
    if (mr[53]) begin
      ex = ex + (EXP_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res_bits <= {1'b0, ex[EXP_W-1:0], (mr[53] ? mr[FRAC_W:1] : mr[FRAC_W-1:0])};
      int_out  <= int_mid;
    end
  end

endmodule

// ----- sv/exi_dmul.sv -----
// Two-stage double precision multiply for positive normal operands.
module exi_dmul import exi_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  dbl_t       a_bits,
  input  dbl_t       b_bits,
  output dbl_t       prod_bits
);

  logic [53:0]      hh;
  logic [52:0]      hl;
  logic [52:0]      lh;
  logic [51:0]      ll;
  logic [12:0]      es;

  logic [105:0]     q;
  logic [105:0]     sh;
  logic [12:0]      ex;
  logic [52:0]      mant;
  logic [53:0]      mr;
  logic             g;
  logic             s;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hh <= 54'({1'b1, a_bits[51:26]}) * 54'({1'b1, b_bits[51:26]});
      hl <= 53'({1'b1, a_bits[51:26]}) * 53'(b_bits[25:0]);
      lh <= 53'(a_bits[25:0]) * 53'({1'b1, b_bits[51:26]});
      ll <= 52'(a_bits[25:0]) * 52'(b_bits[25:0]);
      es <= 13'(a_bits[62:52]) + 13'(b_bits[62:52]);
    end
  end

  always_comb begin
    q = {hh, 52'b0} + 106'({hl, 26'b0}) + 106'({lh, 26'b0}) + 106'(ll);
    if (q[105]) begin
      sh = q;
      ex = es - 13'd1022;
    end else begin
      sh = q << 1;
      ex = es - 13'd1023;
    end
    mant = sh[105:53];
    g    = sh[52];
    s    = |sh[51:0];
    mr   = {1'b0, mant} + 54'(g & (s | mant[0]));
    if (mr[53]) begin
      ex = ex + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_bits <= {1'b0, ex[EXP_W-1:0], (mr[53] ? mr[FRAC_W:1] : mr[FRAC_W-1:0])};
    end
  end

endmodule

// ----- tb/exp_table_interpolate_checker.sv -----
// Checker for the table-based exponential: predicts each result and compares it.
`timescale 1ns / 1ps
module exp_table_interpolate_checker import exi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    arg_valid,
  input  logic                    arg_ready,
  input  logic signed [ARG_W-1:0] arg_value,
  input  logic                    res_valid,
  input  logic                    res_ready,
  input  logic [63:0]             exp_bits,
  input  logic                    was_clamped,
  output int                      fail_count,
  output int                      pending_count
);

  typedef struct packed {
    logic [63:0] bits;
    logic        clamped;
  } exp_result_t;

  exp_result_t pending_results[$];
  real frac_table [0:FRAC_STEPS];
  real int_table  [0:INT_SPAN];

  function automatic real taylor_exp(real y);
    real sum;
    real term;
    sum  = 1.0;
    term = 1.0;
    for (int k = 1; k < 30; k++) begin
      term = term * y;
      term = term / real'(k);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic real raise_power(real base, int n);
    real acc;
    real b;
    int  e;
    acc = 1.0;
    b   = base;
    e   = n;
    while (e != 0) begin
      if (e[0]) begin
        acc = acc * b;
      end
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

  initial begin
    for (int k = 0; k <= FRAC_STEPS; k++) begin
      frac_table[k] = taylor_exp(real'(k) / real'(FRAC_STEPS));
    end
    for (int j = 0; j <= INT_SPAN; j++) begin
      if (j >= HALF_SPAN) begin
        int_table[j] = raise_power(taylor_exp(1.0), j - HALF_SPAN);
      end else begin
        int_table[j] = raise_power(taylor_exp(-1.0), HALF_SPAN - j);
      end
    end
  end

  function automatic exp_result_t predict_exp(logic signed [ARG_W-1:0] arg);
    longint      lim;
    longint      x;
    longint      u;
    longint      ipart;
    longint      fpart;
    longint      t;
    longint      r;
    longint      resid;
    real         m;
    real         res;
    exp_result_t out;
    lim         = longint'(HALF_SPAN) <<< FRAC_BITS;
    x           = longint'(arg);
    out.clamped = 1'b0;
    if (x > lim) begin
      x           = lim;
      out.clamped = 1'b1;
    end else if (x < -lim) begin
      x           = -lim;
      out.clamped = 1'b1;
    end
    u     = x + lim;
    ipart = u >>> FRAC_BITS;
    fpart = u & ((64'd1 << FRAC_BITS) - 1);
    if (ipart > INT_SPAN) begin
      ipart = INT_SPAN;
    end
    t = fpart * FRAC_STEPS;
    r = (t + (64'd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > FRAC_STEPS) begin
      r = FRAC_STEPS;
    end
    resid = t - (r <<< FRAC_BITS);
    m     = real'(resid) / real'(64'd1 << FRAC_BITS);
    m     = m / real'(FRAC_STEPS);
    m     = 1.0 + m;
    res   = frac_table[r] * m;
    res   = res * int_table[ipart];
    out.bits = $realtobits(res);
    return out;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    exp_result_t want;
    if (!rst) begin
      if (arg_valid && arg_ready) begin
        pending_results.push_back(predict_exp(arg_value));
      end
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (exp_bits !== want.bits) begin
            report_mismatch($sformatf("exp_bits %h, expected %h", exp_bits, want.bits));
          end
          if (was_clamped !== want.clamped) begin
            report_mismatch($sformatf("was_clamped %b, expected %b", was_clamped,
                                      want.clamped));
          end
        end
      end
      pending_count <= pending_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives argument requests and result stalls, and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import exi_pkg::*;

  localparam longint SPAN_LIMIT = longint'(HALF_SPAN) <<< FRAC_BITS;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    arg_valid = 1'b0;
  logic                    arg_ready;
  logic signed [ARG_W-1:0] arg_value = '0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic [63:0]             exp_bits;
  logic                    was_clamped;
  int                      fail_count;
  int                      pending_count;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  // While set, the receiver holds off entirely so that the pipeline backs up.
  logic hold_off = 1'b0;

  always #4 clk = ~clk;

  exp_table_interpolate dut (
    .clk         (clk),
    .rst         (rst),
    .arg_valid   (arg_valid),
    .arg_ready   (arg_ready),
    .arg_value   (arg_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .exp_bits    (exp_bits),
    .was_clamped (was_clamped)
  );

  exp_table_interpolate_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .arg_valid     (arg_valid),
    .arg_ready     (arg_ready),
    .arg_value     (arg_value),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .exp_bits      (exp_bits),
    .was_clamped   (was_clamped),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // The receiver decides its ready afresh every cycle.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Sends one argument request, with a random idle gap before it, and
  // returns once the block has taken it. Valid stays high across
  // back-to-back requests, so it is only lowered during a gap.
  task automatic send_arg(input logic signed [ARG_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      arg_valid <= 1'b0;
      @(posedge clk);
    end
    arg_valid <= 1'b1;
    arg_value <= value;
    @(posedge clk);
    while (!arg_ready) begin
      @(posedge clk);
    end
  endtask

  // A random argument. Most land inside the table span, where all the
  // interpolation paths are; some run anywhere across the full field range.
  function automatic logic signed [ARG_W-1:0] random_arg();
    longint v;
    case ($urandom_range(9))
      0, 1: begin
        return ARG_W'($urandom);
      end
      2: begin
        // Close to a span edge, on either side.
        v = SPAN_LIMIT + longint'($urandom_range(64)) - 32;
        return ($urandom_range(1) != 0) ? ARG_W'(v) : ARG_W'(-v);
      end
      3: begin
        // Fractions that sit right at a rounding boundary of the table step.
        v = (longint'($urandom_range(2 * HALF_SPAN * FRAC_STEPS)) <<< (FRAC_BITS - FRAC_LOG2))
            - SPAN_LIMIT + longint'($urandom_range(2)) - 1
            - (longint'(1) <<< (FRAC_BITS - FRAC_LOG2 - 1));
        return ARG_W'(v);
      end
      default: begin
        v = longint'($urandom_range(2 * HALF_SPAN * 1024 * 1024)) - SPAN_LIMIT;
        return ARG_W'(v);
      end
    endcase
  endfunction

  // Waits until every result has come back, with latency margin after it.
  task automatic drain();
    arg_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic signed [ARG_W-1:0] directed [$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: field extremes, span edges just inside, on and
    // just outside, zero, negative values with a fraction (true floor),
    // and a fraction that rounds up to the last fraction table entry.
    directed = '{
      ARG_W'(-268435456), ARG_W'(268435455), ARG_W'(0), ARG_W'(-1), ARG_W'(1),
      ARG_W'(SPAN_LIMIT), ARG_W'(-SPAN_LIMIT), ARG_W'(SPAN_LIMIT + 1),
      ARG_W'(-SPAN_LIMIT - 1), ARG_W'(SPAN_LIMIT - 1), ARG_W'(-SPAN_LIMIT + 1),
      ARG_W'(-(1 <<< FRAC_BITS) / 2), ARG_W'(-(3 <<< FRAC_BITS) / 2),
      ARG_W'((1 <<< FRAC_BITS) - 1), ARG_W'((1 <<< FRAC_BITS) - 256),
      ARG_W'(-256), ARG_W'(1 <<< FRAC_BITS), ARG_W'(-(1 <<< FRAC_BITS)),
      ARG_W'(512), ARG_W'(511), ARG_W'(-512), ARG_W'(-513),
      ARG_W'(29'h0AAAAAAA), ARG_W'(29'h15555555)
    };
    foreach (directed[i]) begin
      send_arg(directed[i]);
    end
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = (phase == 1) ? 51 : (phase == 3) ? 34 : 0;
      receiver_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 34 : 0;
      for (int n = 0; n < 230; n++) begin
        send_arg(random_arg());
      end
      drain();
    end

    // Back-pressure: the receiver holds off while requests keep coming,
    // so the pipeline fills and the block stops taking arguments.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (40) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < 30; n++) begin
          send_arg(random_arg());
        end
      end
    join
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/exi_pkg.sv
sv/exi_front.sv
sv/exi_rom.sv
sv/exi_scale.sv
sv/exi_dmul.sv
sv/exp_table_interpolate.sv
tb/exp_table_interpolate_checker.sv
tb/tb.sv
